### src/sms_pkg.sv
package sms_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 64;
  localparam int unsigned NUM_STACKS_DEF = 3;
  localparam int unsigned DATA_BITS_DEF  = 32;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned SID_W  = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

### src/sms_pool_mem.sv
module sms_pool_mem #(
  parameter int unsigned POOL_DEPTH = 64,
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned ADDR_BITS  = 6,
  parameter int unsigned PTR_BITS   = 7
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [PTR_BITS-1:0]  rd_link,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_link_en,
  input  logic                 wr_data_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [PTR_BITS-1:0]  wr_link,
  input  logic [DATA_BITS-1:0] wr_data
);

  logic [PTR_BITS-1:0]  link_mem [POOL_DEPTH];
  logic [DATA_BITS-1:0] data_mem [POOL_DEPTH];
  logic [PTR_BITS-1:0]  rd_link_r;
  logic [DATA_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_link_en) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (wr_data_en) begin
      data_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_link_r <= link_mem[rd_addr];
      rd_data_r <= data_mem[rd_addr];
    end
  end

  assign rd_link = rd_link_r;
  assign rd_data = rd_data_r;

endmodule

### src/sms_ctrl.sv
module sms_ctrl
  import sms_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 64,
  parameter int unsigned NUM_STACKS = 3,
  parameter int unsigned DATA_BITS  = 32,
  parameter int unsigned ADDR_BITS  = 6,
  parameter int unsigned PTR_BITS   = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [SID_W-1:0]     in_stack_id,
  input  logic [WORD_W-1:0]    in_push_value,
  output logic                 out_valid,
  output logic [WORD_W-1:0]    out_read_value,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_stack_empty,
  output logic                 out_pool_full,
  output logic                 mem_rd_en,
  output logic [ADDR_BITS-1:0] mem_rd_addr,
  input  logic [PTR_BITS-1:0]  mem_rd_link,
  input  logic [DATA_BITS-1:0] mem_rd_data,
  output logic                 mem_wr_link_en,
  output logic                 mem_wr_data_en,
  output logic [ADDR_BITS-1:0] mem_wr_addr,
  output logic [PTR_BITS-1:0]  mem_wr_link,
  output logic [DATA_BITS-1:0] mem_wr_data
);

  localparam int unsigned SID_BITS = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned EXT_BITS = (DATA_BITS > WORD_W) ? DATA_BITS : WORD_W;
  localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(POOL_DEPTH);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t               state_r, state_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [SID_BITS-1:0]  sid_r, sid_nxt;
  logic                 sid_ok_r, sid_ok_nxt;
  logic [DATA_BITS-1:0] word_r, word_nxt;
  logic [PTR_BITS-1:0]  ptr_r, ptr_nxt;
  logic [PTR_BITS-1:0]  free_head_r, free_head_nxt;
  logic [PTR_BITS-1:0]  fill_r, fill_nxt;
  logic [PTR_BITS-1:0]  heads_r [NUM_STACKS];
  logic                 head_we;
  logic [PTR_BITS-1:0]  head_wval;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    rd_val_r, rd_val_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic                 empty_r, empty_nxt;
  logic                 full_r, full_nxt;

  logic                 in_sid_ok;
  logic [SID_BITS-1:0]  in_sid;
  logic [PTR_BITS-1:0]  in_head;
  logic [PTR_BITS-1:0]  sel_ptr;
  logic [PTR_BITS-1:0]  cur_head;
  logic [PTR_BITS-1:0]  link_val;
  logic                 ptr_is_entry;
  logic [EXT_BITS-1:0]  word_ext;
  logic [EXT_BITS-1:0]  data_ext;

  assign in_sid    = SID_BITS'(in_stack_id);
  assign in_sid_ok = (int'(in_stack_id) < int'(NUM_STACKS));
  assign in_head   = in_sid_ok ? heads_r[in_sid] : NIL;
  assign sel_ptr   = (in_kind == KIND_PUSH) ? free_head_r : in_head;
  assign word_ext  = EXT_BITS'(in_push_value);

  assign cur_head     = sid_ok_r ? heads_r[sid_r] : NIL;
  assign ptr_is_entry = (ptr_r < NIL);
  // entries at or above the fill mark were never written, so their link is taken as the next entry
  assign link_val     = (ptr_r >= fill_r) ? PTR_BITS'(ptr_r + 1'b1) : mem_rd_link;
  assign data_ext     = EXT_BITS'(mem_rd_data);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    sid_nxt        = sid_r;
    sid_ok_nxt     = sid_ok_r;
    word_nxt       = word_r;
    ptr_nxt        = ptr_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    head_we        = 1'b0;
    head_wval      = ptr_r;
    out_valid_nxt  = 1'b0;
    rd_val_nxt     = rd_val_r;
    status_nxt     = status_r;
    empty_nxt      = empty_r;
    full_nxt       = full_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = sel_ptr[ADDR_BITS-1:0];
    mem_wr_link_en = 1'b0;
    mem_wr_data_en = 1'b0;
    mem_wr_addr    = ptr_r[ADDR_BITS-1:0];
    mem_wr_link    = free_head_r;
    mem_wr_data    = word_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_EXEC;
          kind_nxt   = in_kind;
          sid_nxt    = in_sid;
          sid_ok_nxt = in_sid_ok;
          word_nxt   = word_ext[DATA_BITS-1:0];
          ptr_nxt    = sel_ptr;
          mem_rd_en  = (sel_ptr < NIL);
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        rd_val_nxt    = '0;
        status_nxt    = STAT_OK;
        empty_nxt     = (cur_head >= NIL);
        full_nxt      = (free_head_r >= NIL);
        if (!sid_ok_r) begin
          status_nxt = STAT_EMPTY;
          empty_nxt  = 1'b1;
        end else begin
          case (kind_r)
            KIND_PUSH: begin
              if (!ptr_is_entry) begin
                status_nxt = STAT_FULL;
              end else begin
                free_head_nxt  = link_val;
                head_we        = 1'b1;
                head_wval      = ptr_r;
                mem_wr_link_en = 1'b1;
                mem_wr_data_en = 1'b1;
                mem_wr_link    = cur_head;
                if (ptr_r == fill_r) begin
                  fill_nxt = PTR_BITS'(fill_r + 1'b1);
                end
                empty_nxt = 1'b0;
                full_nxt  = (link_val >= NIL);
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (!ptr_is_entry) begin
                status_nxt = STAT_EMPTY;
              end else begin
                rd_val_nxt = data_ext[WORD_W-1:0];
                if (kind_r == KIND_POP) begin
                  head_we        = 1'b1;
                  head_wval      = link_val;
                  mem_wr_link_en = 1'b1;
                  mem_wr_link    = free_head_r;
                  free_head_nxt  = ptr_r;
                  empty_nxt      = (link_val >= NIL);
                  full_nxt       = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < int'(NUM_STACKS); i++) begin
        heads_r[i] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) begin
        heads_r[sid_r] <= head_wval;
      end
    end
    kind_r   <= kind_nxt;
    sid_r    <= sid_nxt;
    sid_ok_r <= sid_ok_nxt;
    word_r   <= word_nxt;
    ptr_r    <= ptr_nxt;
    rd_val_r <= rd_val_nxt;
    status_r <= status_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
  end

  assign busy            = (state_r == ST_EXEC);
  assign out_valid       = out_valid_r;
  assign out_read_value  = rd_val_r;
  assign out_status      = status_r;
  assign out_stack_empty = empty_r;
  assign out_pool_full   = full_r;

endmodule

### src/shared_pool_multi_stack.sv
// Several stacks share one pool of entries held in a data memory and a link
// memory, with unused entries chained on a free list. In each operation (push,
// pop or peek) the link and data words are read from the synchronous memory
// in the accept cycle, and the heads and link memory are updated in the
// following busy cycle; no new start is taken while busy. The result appears
// on the out_ ports for exactly one cycle, marked by out_valid, in the cycle
// right after the busy cycle; the receiver cannot stall it and must capture
// it then. A push on a full pool or a pop or peek on an empty stack changes
// nothing and reports the matching status. No clearing pass is needed after
// reset.
module shared_pool_multi_stack
  import sms_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned NUM_STACKS = NUM_STACKS_DEF,
  parameter int unsigned DATA_BITS  = DATA_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] in_kind,
  input  logic [SID_W-1:0]  in_stack_id,
  input  logic [WORD_W-1:0] in_push_value,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_read_value,
  output logic [STAT_W-1:0] out_status,
  output logic              out_stack_empty,
  output logic              out_pool_full
);

  localparam int unsigned ADDR_BITS = $clog2(POOL_DEPTH);
  localparam int unsigned PTR_BITS  = $clog2(POOL_DEPTH + 1);

  logic                 mem_rd_en;
  logic [ADDR_BITS-1:0] mem_rd_addr;
  logic [PTR_BITS-1:0]  mem_rd_link;
  logic [DATA_BITS-1:0] mem_rd_data;
  logic                 mem_wr_link_en;
  logic                 mem_wr_data_en;
  logic [ADDR_BITS-1:0] mem_wr_addr;
  logic [PTR_BITS-1:0]  mem_wr_link;
  logic [DATA_BITS-1:0] mem_wr_data;

  sms_ctrl #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_STACKS (NUM_STACKS),
    .DATA_BITS  (DATA_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .PTR_BITS   (PTR_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_stack_id     (in_stack_id),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_stack_empty (out_stack_empty),
    .out_pool_full   (out_pool_full),
    .mem_rd_en       (mem_rd_en),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_link     (mem_rd_link),
    .mem_rd_data     (mem_rd_data),
    .mem_wr_link_en  (mem_wr_link_en),
    .mem_wr_data_en  (mem_wr_data_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_link     (mem_wr_link),
    .mem_wr_data     (mem_wr_data)
  );

  sms_pool_mem #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_BITS  (DATA_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .PTR_BITS   (PTR_BITS)
  ) u_pool_mem (
    .clk        (clk),
    .rd_en      (mem_rd_en),
    .rd_addr    (mem_rd_addr),
    .rd_link    (mem_rd_link),
    .rd_data    (mem_rd_data),
    .wr_link_en (mem_wr_link_en),
    .wr_data_en (mem_wr_data_en),
    .wr_addr    (mem_wr_addr),
    .wr_link    (mem_wr_link),
    .wr_data    (mem_wr_data)
  );

endmodule
